// File: rtl/msprx_pkg.sv
// msprx_pkg: shared types, constants and the crc-8 dvb-s2 byte fold
// for the msp v2 frame receiver; no dependencies
`timescale 1ns / 1ps

package msprx_pkg;

  localparam logic [7:0]  CHAR_DOLLAR     = 8'h24;
  localparam logic [7:0]  CHAR_X          = 8'h58;
  localparam logic [7:0]  CHAR_GT         = 8'h3E;
  localparam logic [7:0]  CRC_POLY        = 8'hD5;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'hFFFF;

  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef enum logic [9:0] {
    PH_DOLLAR = 10'b00_0000_0001,
    PH_X      = 10'b00_0000_0010,
    PH_GT     = 10'b00_0000_0100,
    PH_FLAG   = 10'b00_0000_1000,
    PH_ID_LO  = 10'b00_0001_0000,
    PH_ID_HI  = 10'b00_0010_0000,
    PH_SZ_LO  = 10'b00_0100_0000,
    PH_SZ_HI  = 10'b00_1000_0000,
    PH_DATA   = 10'b01_0000_0000,
    PH_CRC    = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] payload_index;
    logic [7:0]  payload_value;
    logic [15:0] message_id;
    logic [7:0]  frame_flag;
    logic [15:0] payload_size;
    logic        crc_ok;
  } result_t;

  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/msprx_parser.sv
// msprx_parser: header hunt, field capture, crc accumulation and result decode
// depends on msprx_pkg
`timescale 1ns / 1ps

module msprx_parser
  import msprx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] max_payload,
  output logic        res_vld,
  output result_t     res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] size_r, size_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  crc_step;
  logic [15:0] size_full;

  assign crc_step  = crc_fold(crc_r, rx_byte);
  assign size_full = {rx_byte, size_r[7:0]};

  always_comb begin
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    id_nxt    = id_r;
    size_nxt  = size_r;
    flag_nxt  = flag_r;
    count_nxt = count_r;
    res_vld   = 1'b0;
    res.result_kind   = KIND_PAYLOAD;
    res.payload_index = count_r;
    res.payload_value = rx_byte;
    res.message_id    = id_r;
    res.frame_flag    = flag_r;
    res.payload_size  = size_r;
    res.crc_ok        = 1'b0;
    case (phase_r)
      PH_X: begin
        phase_nxt = (rx_byte == CHAR_X) ? PH_GT :
                    (rx_byte == CHAR_DOLLAR) ? PH_X : PH_DOLLAR;
      end
      PH_GT: begin
        phase_nxt = (rx_byte == CHAR_GT) ? PH_FLAG :
                    (rx_byte == CHAR_DOLLAR) ? PH_X : PH_DOLLAR;
      end
      PH_FLAG: begin
        flag_nxt  = rx_byte;
        crc_nxt   = crc_fold(8'h00, rx_byte);
        phase_nxt = PH_ID_LO;
      end
      PH_ID_LO: begin
        id_nxt    = {8'h00, rx_byte};
        crc_nxt   = crc_step;
        phase_nxt = PH_ID_HI;
      end
      PH_ID_HI: begin
        id_nxt    = {rx_byte, id_r[7:0]};
        crc_nxt   = crc_step;
        phase_nxt = PH_SZ_LO;
      end
      PH_SZ_LO: begin
        size_nxt  = {8'h00, rx_byte};
        crc_nxt   = crc_step;
        phase_nxt = PH_SZ_HI;
      end
      PH_SZ_HI: begin
        size_nxt  = size_full;
        crc_nxt   = crc_step;
        count_nxt = 16'h0000;
        phase_nxt = (size_full == 16'h0000) ? PH_CRC : PH_DATA;
      end
      PH_DATA: begin
        crc_nxt   = crc_step;
        res_vld   = (count_r < max_payload);
        count_nxt = count_r + 16'h0001;
        if (count_nxt >= size_r) begin
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        res_vld           = 1'b1;
        res.result_kind   = KIND_FRAME_END;
        res.payload_index = 16'h0000;
        res.payload_value = 8'h00;
        res.crc_ok        = (crc_r == rx_byte);
        phase_nxt         = PH_DOLLAR;
      end
      default: begin
        phase_nxt = (rx_byte == CHAR_DOLLAR) ? PH_X : PH_DOLLAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DOLLAR;
      crc_r   <= 8'h00;
      id_r    <= 16'h0000;
      size_r  <= 16'h0000;
      flag_r  <= 8'h00;
      count_r <= 16'h0000;
    end else if (step) begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      id_r    <= id_nxt;
      size_r  <= size_nxt;
      flag_r  <= flag_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/msp_v2_frame_receiver_core.sv
// msp_v2_frame_receiver_core: top level with input register, parser and result register
// depends on msprx_pkg and msprx_parser
`timescale 1ns / 1ps

// Takes one received serial byte per transaction and parses msp v2 frames:
// '$','X','>' header, flag, little-endian id and size, payload, crc-8 dvb-s2
// byte. Each payload byte with index below cfg max_payload gives a payload
// result; the crc byte gives a frame-end result with crc_ok. One byte is
// accepted every cycle into the input register while in_stall is low; its
// result is presented from the result register behind the combinational parse
// and crc fold. in_stall rises only while a result waits on out_stall.
// cfg_wr_data is taken at any edge with cfg_wr_en high; reset value 65535.

module msp_v2_frame_receiver_core
  import msprx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [15:0] out_payload_index,
  output logic [7:0]  out_payload_value,
  output logic [15:0] out_message_id,
  output logic [7:0]  out_frame_flag,
  output logic [15:0] out_payload_size,
  output logic        out_crc_ok
);

  logic [15:0] max_payload_r;
  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        out_vld_r;
  result_t     out_res_r;
  logic        adv;
  logic        res_vld;
  result_t     res;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_wr_en) begin
      max_payload_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  msprx_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .rx_byte     (in_byte_r),
    .max_payload (max_payload_r),
    .res_vld     (res_vld),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res_vld;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_result_kind   = out_res_r.result_kind;
  assign out_payload_index = out_res_r.payload_index;
  assign out_payload_value = out_res_r.payload_value;
  assign out_message_id    = out_res_r.message_id;
  assign out_frame_flag    = out_res_r.frame_flag;
  assign out_payload_size  = out_res_r.payload_size;
  assign out_crc_ok        = out_res_r.crc_ok;

  // held input byte survives a stall
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(in_byte_r))
    else $error("input register lost a stalled byte");

  // frame-end results carry zero index and value
  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.result_kind == KIND_FRAME_END |->
      out_res_r.payload_index == 16'h0000 && out_res_r.payload_value == 8'h00)
    else $error("frame-end result with payload fields set");

  // payload results stay within the forward limit and the announced size
  a_payload_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.result_kind == KIND_PAYLOAD |->
      out_res_r.payload_index < max_payload_r &&
      out_res_r.payload_index < out_res_r.payload_size && !out_res_r.crc_ok)
    else $error("payload result out of range");

  // a waiting result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |-> !adv)
    else $error("parser advanced over a stalled result");

endmodule

// File: tb/testbench.sv
// testbench for msp_v2_frame_receiver_core: directed and random msp v2 byte streams,
// checked against a scoreboard that parses frames and folds crc-8 dvb-s2 on its own
// depends on msprx_pkg and the receiver rtl
`timescale 1ns / 1ps

module testbench;
  import msprx_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;

  typedef logic [7:0] byte_q_t[$];

  class frame_scoreboard;
    phase_t      phase;
    logic [7:0]  crc;
    logic [7:0]  flag;
    logic [15:0] msg_id;
    logic [15:0] size;
    logic [15:0] count;
    logic [15:0] limit;
    result_t     expected_q[$];
    int          errors;
    int          bytes_seen;
    int          payloads;
    int          frame_ends;
    int          bad_crcs;

    function new();
      phase      = PH_DOLLAR;
      crc        = '0;
      flag       = '0;
      msg_id     = '0;
      size       = '0;
      count      = '0;
      limit      = MAX_PAYLOAD_RST;
      errors     = 0;
      bytes_seen = 0;
      payloads   = 0;
      frame_ends = 0;
      bad_crcs   = 0;
    endfunction

    static function logic [7:0] crc_step(logic [7:0] acc, logic [7:0] d);
      logic [7:0] r;
      r = acc ^ d;
      repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
      return r;
    endfunction

    function void set_limit(logic [15:0] v);
      limit = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_rx_byte(logic [7:0] b);
      result_t r;
      r = '0;
      bytes_seen++;
      case (phase)
        PH_X: begin
          phase = (b == CHAR_X) ? PH_GT : ((b == CHAR_DOLLAR) ? PH_X : PH_DOLLAR);
        end
        PH_GT: begin
          phase = (b == CHAR_GT) ? PH_FLAG : ((b == CHAR_DOLLAR) ? PH_X : PH_DOLLAR);
        end
        PH_FLAG: begin
          flag  = b;
          crc   = crc_step(8'h00, b);
          phase = PH_ID_LO;
        end
        PH_ID_LO: begin
          msg_id = {8'h00, b};
          crc    = crc_step(crc, b);
          phase  = PH_ID_HI;
        end
        PH_ID_HI: begin
          msg_id[15:8] = b;
          crc          = crc_step(crc, b);
          phase        = PH_SZ_LO;
        end
        PH_SZ_LO: begin
          size  = {8'h00, b};
          crc   = crc_step(crc, b);
          phase = PH_SZ_HI;
        end
        PH_SZ_HI: begin
          size[15:8] = b;
          crc        = crc_step(crc, b);
          count      = '0;
          phase      = (size == 16'd0) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          crc = crc_step(crc, b);
          if (count < limit) begin
            r.result_kind   = KIND_PAYLOAD;
            r.payload_index = count;
            r.payload_value = b;
            r.message_id    = msg_id;
            r.frame_flag    = flag;
            r.payload_size  = size;
            expected_q.push_back(r);
          end
          count = count + 16'd1;
          if (count >= size) begin
            phase = PH_CRC;
          end
        end
        PH_CRC: begin
          r.result_kind  = KIND_FRAME_END;
          r.message_id   = msg_id;
          r.frame_flag   = flag;
          r.payload_size = size;
          r.crc_ok       = (crc == b);
          expected_q.push_back(r);
          phase = PH_DOLLAR;
        end
        default: begin
          phase = (b == CHAR_DOLLAR) ? PH_X : PH_DOLLAR;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0b index %h value %h",
                 $time, got.result_kind, got.payload_index, got.payload_value);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.result_kind == KIND_FRAME_END) begin
        frame_ends++;
        if (!got.crc_ok) bad_crcs++;
      end else begin
        payloads++;
      end
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("payload_index", want.payload_index, got.payload_index);
      compare_field("payload_value", want.payload_value, got.payload_value);
      compare_field("message_id", want.message_id, got.message_id);
      compare_field("frame_flag", want.frame_flag, got.frame_flag);
      compare_field("payload_size", want.payload_size, got.payload_size);
      compare_field("crc_ok", want.crc_ok, got.crc_ok);
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte  = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic        out_result_kind;
  logic [15:0] out_payload_index;
  logic [7:0]  out_payload_value;
  logic [15:0] out_message_id;
  logic [7:0]  out_frame_flag;
  logic [15:0] out_payload_size;
  logic        out_crc_ok;

  bit          idle_on    = 1'b0;
  int          stall_left = 0;
  int          quiet      = 0;
  byte_q_t     wire_q;
  frame_scoreboard board;

  msp_v2_frame_receiver_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_payload_index (out_payload_index),
    .out_payload_value (out_payload_value),
    .out_message_id    (out_message_id),
    .out_frame_flag    (out_frame_flag),
    .out_payload_size  (out_payload_size),
    .out_crc_ok        (out_crc_ok)
  );

  always #2 clk = ~clk;

  // result sampling, receiver stall bursts and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result({out_result_kind, out_payload_index, out_payload_value,
                          out_message_id, out_frame_flag, out_payload_size, out_crc_ok});
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("** msp_v2_frame_receiver_core: FAILED **");
      $finish;
    end
    if (stall_left > 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 12);
    end
    out_stall <= (stall_left > 0);
  end

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CHAR_GT);
    return b;
  endfunction

  function automatic byte_q_t random_body(int n);
    byte_q_t body;
    for (int i = 0; i < n; i++) body.push_back(8'($urandom));
    return body;
  endfunction

  function automatic void queue_frame(logic [7:0] flag, logic [15:0] msg_id,
                                      byte_q_t body, bit good_crc);
    logic [15:0] size;
    logic [7:0]  crc;
    logic [7:0]  fields[5];
    size   = 16'(body.size());
    fields = '{flag, msg_id[7:0], msg_id[15:8], size[7:0], size[15:8]};
    crc    = 8'h00;
    wire_q.push_back(CHAR_DOLLAR);
    wire_q.push_back(CHAR_X);
    wire_q.push_back(CHAR_GT);
    foreach (fields[i]) begin
      crc = frame_scoreboard::crc_step(crc, fields[i]);
      wire_q.push_back(fields[i]);
    end
    foreach (body[i]) begin
      crc = frame_scoreboard::crc_step(crc, body[i]);
      wire_q.push_back(body[i]);
    end
    if (!good_crc) crc ^= 8'h01 << $urandom_range(0, 7);
    wire_q.push_back(crc);
  endfunction

  function automatic void queue_random_unit();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 48) : $urandom_range(0, 10);
      queue_frame(8'($urandom), 16'($urandom), random_body(n), $urandom_range(0, 4) != 0);
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 4)) wire_q.push_back(noise_byte());
    end else if (pick < 92) begin
      wire_q.push_back(CHAR_DOLLAR);
      wire_q.push_back(noise_byte());
    end else begin
      wire_q.push_back(CHAR_DOLLAR);
      wire_q.push_back(CHAR_X);
      wire_q.push_back(noise_byte());
    end
  endfunction

  // sends n queued bytes, or all of them when n is negative
  task automatic send_pending(input int n);
    int sent;
    sent = 0;
    while (wire_q.size() > 0 && (n < 0 || sent < n)) begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      in_valid   <= 1'b1;
      in_rx_byte <= wire_q[0];
      do @(posedge clk); while (in_stall);
      board.note_rx_byte(wire_q.pop_front());
      sent++;
    end
  endtask

  task automatic write_max_payload(input logic [15:0] v);
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_limit(v);
  endtask

  task automatic run_phase(input int n);
    while (wire_q.size() < n + 64) queue_random_unit();
    send_pending(n);
  endtask

  initial begin
    logic [15:0] limits[6];
    byte_q_t     body;
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // broken headers, dollar restarts, empty payload, bad crc, byte extremes
    wire_q = '{CHAR_DOLLAR, 8'h51, CHAR_DOLLAR, CHAR_DOLLAR, CHAR_X};
    body.delete();
    queue_frame(8'hFF, 16'hFFFF, body, 1'b1);
    wire_q.push_back(CHAR_DOLLAR);
    wire_q.push_back(CHAR_X);
    wire_q.push_back(8'h51);
    body = '{8'hFF, 8'h00};
    queue_frame(8'h00, 16'h0000, body, 1'b0);
    send_pending(-1);

    limits = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 6)), 16'($urandom), 16'd3};
    foreach (limits[i]) begin
      write_max_payload(limits[i]);
      idle_on = (i % 3 != 2);
      run_phase(115);
    end

    // no idling from here on, ending with a long frame
    write_max_payload(MAX_PAYLOAD_RST);
    idle_on = 1'b0;
    send_pending(-1);
    queue_frame(8'($urandom), 16'($urandom), random_body(48), 1'b1);
    send_pending(-1);
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("received %0d bytes under several max_payload settings, including 0 and 65535",
             board.bytes_seen);
    $display("checked %0d payload results and %0d frame ends, %0d of them with a bad crc",
             board.payloads, board.frame_ends, board.bad_crcs);
    if (board.errors == 0) begin
      $display("** msp_v2_frame_receiver_core: PASSED **");
    end else begin
      $display("** msp_v2_frame_receiver_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/msprx_pkg.sv
rtl/msprx_parser.sv
rtl/msp_v2_frame_receiver_core.sv
tb/testbench.sv
